/* rtl/sgp_crc_pkg.sv */
package sgp_crc_pkg;

    localparam int RAW_W   = 12;
    localparam int DEG_W   = 8;
    localparam int TICK_W  = 13;
    localparam int MAG_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int CRC_W   = 16;
    localparam int IDX_W   = 4;

    // degrees = round(|raw - centre| * 45 / 512)
    localparam logic [MAG_W-1:0]  RAW_CENTRE = 12'd2048;
    localparam logic [5:0]        DEG_SCALE  = 6'd45;
    localparam logic [17:0]       DEG_HALF   = 18'd256;
    localparam int                DEG_SHIFT  = 9;

    // ticks = round(deg * 512 / 45) = floor((deg * 1024 + 45) / 90)
    // floor(n / 90) = (n * RECIP_90) >> 24, exact for n below 2^18
    localparam logic [17:0]       TICK_BIAS  = 18'd45;
    localparam logic [17:0]       RECIP_90   = 18'd186414;
    localparam int                RECIP_SHIFT = 24;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h8005;
    localparam logic [CRC_W-1:0]  CRC_INIT   = 16'h0000;

    // byte positions within the packet
    localparam logic [IDX_W-1:0]  POS_ID     = 4'd4;
    localparam logic [IDX_W-1:0]  POS_TICKS0 = 4'd10;
    localparam logic [IDX_W-1:0]  POS_TICKS1 = 4'd11;
    localparam logic [IDX_W-1:0]  POS_TICKS2 = 4'd12;
    localparam logic [IDX_W-1:0]  POS_TICKS3 = 4'd13;
    localparam logic [IDX_W-1:0]  POS_CRC_LO = 4'd14;
    localparam logic [IDX_W-1:0]  POS_CRC_HI = 4'd15;

    // fixed bytes of the packet; variable slots hold zero
    localparam logic [BYTE_W-1:0] PKT_TEMPLATE [16] = '{
        8'hFF, 8'hFF, 8'hFD, 8'h00,
        8'h00, 8'h09, 8'h00, 8'h03,
        8'h54, 8'h02, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00
    };

    // advance an unreflected CRC-16 by one byte, MSB first
    function automatic logic [CRC_W-1:0] crc16_step(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data
    );
        logic [CRC_W-1:0] c;
        c = crc ^ {data, 8'h00};
        for (int b = 0; b < 8; b++)
        begin
            if (c[CRC_W-1])
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/sgp_crc_conv.sv */
module sgp_crc_conv (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [sgp_crc_pkg::RAW_W-1:0]           raw_position,
    output logic                                    tick_valid,
    input  logic                                    tick_ready,
    output logic signed [sgp_crc_pkg::TICK_W-1:0]   ticks
);

    logic                                   raw_valid_reg;
    logic [sgp_crc_pkg::RAW_W-1:0]          raw_reg;
    logic                                   deg_valid_reg;
    logic [sgp_crc_pkg::DEG_W-1:0]          deg_mag_reg;
    logic                                   deg_neg_reg;
    logic                                   tick_valid_reg;
    logic signed [sgp_crc_pkg::TICK_W-1:0]  tick_reg;

    logic                                   deg_load;
    logic                                   tick_load;
    logic [sgp_crc_pkg::MAG_W-1:0]          raw_mag;
    logic [17:0]                            deg_sum;
    logic [sgp_crc_pkg::DEG_W-1:0]          deg_mag_next;
    logic [17:0]                            tick_num;
    logic [35:0]                            tick_prod;
    logic [sgp_crc_pkg::MAG_W-1:0]          tick_mag;
    logic signed [sgp_crc_pkg::TICK_W-1:0]  tick_next;

    assign tick_load = deg_valid_reg && (!tick_valid_reg || tick_ready);
    assign deg_load  = raw_valid_reg && (!deg_valid_reg || tick_load);
    assign in_ready  = !raw_valid_reg || deg_load;

    // distance from centre, then scale to whole degrees
    always_comb
    begin
        if (raw_reg[sgp_crc_pkg::RAW_W-1])
        begin
            raw_mag = {1'b0, raw_reg[sgp_crc_pkg::RAW_W-2:0]};
        end
        else
        begin
            raw_mag = sgp_crc_pkg::RAW_CENTRE - raw_reg;
        end
        deg_sum = 18'(raw_mag) * 18'(sgp_crc_pkg::DEG_SCALE) + sgp_crc_pkg::DEG_HALF;
        deg_mag_next = deg_sum[sgp_crc_pkg::DEG_SHIFT +: sgp_crc_pkg::DEG_W];
    end

    // degrees back to ticks through a reciprocal multiply
    always_comb
    begin
        tick_num  = {deg_mag_reg, 10'd0} + sgp_crc_pkg::TICK_BIAS;
        tick_prod = tick_num * sgp_crc_pkg::RECIP_90;
        tick_mag  = tick_prod[sgp_crc_pkg::RECIP_SHIFT +: sgp_crc_pkg::MAG_W];
        if (deg_neg_reg)
        begin
            tick_next = -$signed({1'b0, tick_mag});
        end
        else
        begin
            tick_next = $signed({1'b0, tick_mag});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_valid_reg  <= 1'b0;
            deg_valid_reg  <= 1'b0;
            tick_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                raw_valid_reg <= in_valid;
            end
            if (!deg_valid_reg || tick_load)
            begin
                deg_valid_reg <= raw_valid_reg;
            end
            if (!tick_valid_reg || tick_ready)
            begin
                tick_valid_reg <= deg_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            raw_reg <= raw_position;
        end
        if (deg_load)
        begin
            deg_mag_reg <= deg_mag_next;
            deg_neg_reg <= !raw_reg[sgp_crc_pkg::RAW_W-1];
        end
        if (tick_load)
        begin
            tick_reg <= tick_next;
        end
    end

    assign tick_valid = tick_valid_reg;
    assign ticks      = tick_reg;

endmodule

/* rtl/sgp_crc_ser.sv */
module sgp_crc_ser (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    tick_valid,
    output logic                                    tick_ready,
    input  logic signed [sgp_crc_pkg::TICK_W-1:0]   ticks,
    input  logic [sgp_crc_pkg::BYTE_W-1:0]          servo_id,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic [sgp_crc_pkg::BYTE_W-1:0]          packet_byte,
    output logic                                    last_byte
);

    logic                                   out_valid_reg;
    logic [sgp_crc_pkg::IDX_W-1:0]          idx_reg;
    logic [sgp_crc_pkg::BYTE_W-1:0]         byte_reg;
    logic                                   last_reg;
    logic [sgp_crc_pkg::CRC_W-1:0]          crc_reg;
    logic signed [sgp_crc_pkg::TICK_W-1:0]  ticks_reg;

    logic                                   fire;
    logic                                   done;
    logic                                   load;
    logic [sgp_crc_pkg::IDX_W-1:0]          idx_inc;
    logic [sgp_crc_pkg::CRC_W-1:0]          crc_adv;
    logic [31:0]                            tick_word;
    logic [sgp_crc_pkg::BYTE_W-1:0]         byte_next;

    assign fire       = out_valid_reg && out_ready;
    assign done       = fire && last_reg;
    assign tick_ready = !out_valid_reg || done;
    assign load       = tick_valid && tick_ready;

    assign idx_inc   = idx_reg + 1'b1;
    assign crc_adv   = sgp_crc_pkg::crc16_step(crc_reg, byte_reg);
    assign tick_word = {{(32 - sgp_crc_pkg::TICK_W){ticks_reg[sgp_crc_pkg::TICK_W-1]}},
                        ticks_reg};

    // byte to present after the current one is taken
    always_comb
    begin
        case (idx_inc)
            sgp_crc_pkg::POS_ID:     byte_next = servo_id;
            sgp_crc_pkg::POS_TICKS0: byte_next = tick_word[7:0];
            sgp_crc_pkg::POS_TICKS1: byte_next = tick_word[15:8];
            sgp_crc_pkg::POS_TICKS2: byte_next = tick_word[23:16];
            sgp_crc_pkg::POS_TICKS3: byte_next = tick_word[31:24];
            sgp_crc_pkg::POS_CRC_LO: byte_next = crc_adv[7:0];
            sgp_crc_pkg::POS_CRC_HI: byte_next = crc_reg[15:8];
            default:                 byte_next = sgp_crc_pkg::PKT_TEMPLATE[idx_inc];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else if (fire)
        begin
            idx_reg  <= idx_inc;
            last_reg <= (idx_inc == sgp_crc_pkg::POS_CRC_HI);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ticks_reg <= ticks;
            byte_reg  <= sgp_crc_pkg::PKT_TEMPLATE[0];
            crc_reg   <= sgp_crc_pkg::CRC_INIT;
        end
        else if (fire && !last_reg)
        begin
            byte_reg <= byte_next;
            // fold in header and position bytes only, not the checksum
            if (idx_reg <= sgp_crc_pkg::POS_TICKS3)
            begin
                crc_reg <= crc_adv;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign packet_byte = byte_reg;
    assign last_byte   = last_reg;

endmodule

/* rtl/servo_goal_position_packet_crc16_unit.sv */
// Servo goal-position packet builder.
// Input channel (in_valid/in_ready, raw_position): one raw 12-bit position per
// transaction, 2048 is centre. Each transaction is rounded to whole degrees, mapped
// back to signed ticks, and framed as a 16-byte register-write packet.
// Output channel (out_valid/out_ready, packet_byte, last_byte): one packet byte
// per transaction, low CRC byte then high CRC byte at the end; last_byte marks
// the sixteenth byte.
// Config channel (cfg_valid/cfg_ready, servo_id): always ready; write only while
// no packet is pending. Reset sets servo_id to 1 and empties all stages.
// The first byte of a packet is valid after its input passes the raw, degree and tick
// registers and the serializer's byte register. The serializer sends one byte per
// cycle while out_ready is high and folds the bytes before the CRC into a running CRC-16.
// Three conversion stages sit ahead of the serializer, so input is taken while a
// packet is still going out. When the receiver stalls, the current byte holds,
// the stages fill, and in_ready drops once all are full.
module servo_goal_position_packet_crc16_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sgp_crc_pkg::RAW_W-1:0]       raw_position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sgp_crc_pkg::BYTE_W-1:0]      packet_byte,
    output logic                                last_byte,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sgp_crc_pkg::BYTE_W-1:0]      servo_id
);

    logic [sgp_crc_pkg::BYTE_W-1:0]         servo_id_reg;
    logic                                   tick_valid;
    logic                                   tick_ready;
    logic signed [sgp_crc_pkg::TICK_W-1:0]  ticks;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            servo_id_reg <= 8'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            servo_id_reg <= servo_id;
        end
    end

    sgp_crc_conv u_conv (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .raw_position (raw_position),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .ticks        (ticks)
    );

    sgp_crc_ser u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick_ready   (tick_ready),
        .ticks        (ticks),
        .servo_id     (servo_id_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .packet_byte  (packet_byte),
        .last_byte    (last_byte)
    );

endmodule
